// ----- rtl/shqs_pkg.sv -----
// Package for the subnet host queue selector: codes, states and memory word types.
package shqs_pkg;

  localparam logic [2:0] OP_CLASSIFY  = 3'd0;
  localparam logic [2:0] OP_WR_SUBNET = 3'd1;
  localparam logic [2:0] OP_WR_HOST   = 3'd2;
  localparam logic [2:0] OP_WR_QUEUE  = 3'd3;
  localparam logic [2:0] OP_RD_COUNT  = 3'd4;

  localparam int CntW = 48;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_HSCAN,
    ST_SSCAN,
    ST_QDATA,
    ST_MOD,
    ST_QUPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [3:0]  queue;
    logic [31:0] addr;
  } host_entry_t;

  typedef struct packed {
    logic [15:0]     modulo;
    logic [31:0]     salt;
    logic [CntW-1:0] count;
  } queue_entry_t;

endpackage

// ----- rtl/subnet_host_queue_selector.sv -----
// Top level of the subnet host queue selector.
// Usage:
//   Slave channel s_axis_*: one request per beat, the operation in tuser and the
//   packet and table fields in tdata. Master channel m_axis_*: one result per
//   request, flags selected and dropped in tuser, queue and byte counter in tdata.
// Steps per request, one request at a time:
//   table writes of subnet or host entries: straight to the output register;
//   queue writes and counter reads: one queue memory read for a queue in
//   range, none otherwise, then the output register;
//   classify: one pass over the host memory, which looks up source and
//   destination together, then the subnet slots in order up to the first hit,
//   then a queue memory read and, when the queue samples, a bit-serial
//   remainder and a write-back step.
// Reset: subnet entries are invalid and queue entries read as zero; the host memory
// is cleared by a pass over all its entries during which no request is accepted.
// Stall: the result sits in the output register; a new request is accepted as
// soon as the engine is idle, and its result waits until the register frees.
module subnet_host_queue_selector #(
  parameter int SUBNET_SLOTS = 8,
  parameter int HOST_ENTRIES = 64,
  parameter int QUEUE_COUNT  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_addr[31:0] dst_addr[63:32] packet_length[79:64] slot[85:80]
  // entry_addr[117:86] entry_mask[149:118] entry_queue[153:150]
  // entry_valid[154] drop_modulo[170:155] drop_salt[202:171] zero[207:203]
  input  logic [207:0] s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // queue_number[3:0] dropped_bytes[51:4] zero[55:52]
  output logic [55:0]  m_axis_tdata,
  // selected[0] dropped[1]
  output logic [1:0]   m_axis_tuser
);

  localparam int SIW = (SUBNET_SLOTS > 1) ? $clog2(SUBNET_SLOTS) : 1;
  localparam int HIW = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
  localparam int QIW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int HW  = $bits(shqs_pkg::host_entry_t);
  localparam int QW  = $bits(shqs_pkg::queue_entry_t);

  shqs_pkg::state_e state_q, state_d;

  // latched request
  logic [2:0]  op_q;
  logic [31:0] src_q, dst_q, eaddr_q, emask_q, esalt_q;
  logic [15:0] len_q, emod_q;
  logic [5:0]  slot_q;
  logic [3:0]  equeue_q;
  logic        evalid_q;

  logic [31:0] sub_val_q [SUBNET_SLOTS];
  logic [31:0] sub_mask_q [SUBNET_SLOTS];
  logic [SUBNET_SLOTS-1:0] sub_vld_q;
  logic [QUEUE_COUNT-1:0]  q_vld_q;

  logic [HIW-1:0] hcnt_q;
  logic [SIW-1:0] scnt_q;
  logic [QIW-1:0] qidx_q;
  logic [4:0]     bcnt_q;
  logic           src_hit_q, dst_hit_q;
  logic [3:0]     src_hq_q, dst_hq_q;
  logic [31:0]    sel_addr_q, div_q;
  logic [15:0]    rem_q;
  shqs_pkg::queue_entry_t qent_q;

  logic        pend_sel_q, pend_drop_q;
  logic [3:0]  pend_queue_q;
  logic [47:0] pend_bytes_q;

  logic        mvalid_q;
  logic        out_sel_q, out_drop_q;
  logic [3:0]  out_queue_q;
  logic [47:0] out_bytes_q;

  // memory ports
  logic                   h_we;
  logic [HIW-1:0]         h_waddr, h_raddr;
  shqs_pkg::host_entry_t  h_wdata, h_rdata;
  logic                   q_we;
  logic [QIW-1:0]         q_waddr, q_raddr;
  shqs_pkg::queue_entry_t q_wdata, q_rdata, q_ent;

  shqs_ram #(.WIDTH(HW), .DEPTH(HOST_ENTRIES)) u_host_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  shqs_ram #(.WIDTH(QW), .DEPTH(QUEUE_COUNT)) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(q_wdata),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  logic slot_in_sub, slot_in_host, slot_in_q;
  assign slot_in_sub  = 32'(slot_q) < SUBNET_SLOTS;
  assign slot_in_host = 32'(slot_q) < HOST_ENTRIES;
  assign slot_in_q    = 32'(slot_q) < QUEUE_COUNT;

  // subnet scan step
  logic        s_src, s_dst, s_hit, s_qin;
  logic [3:0]  s_queue;
  logic [31:0] s_addr;
  always_comb begin
    s_src   = sub_vld_q[scnt_q] && src_hit_q &&
              ((src_q & sub_mask_q[scnt_q]) == sub_val_q[scnt_q]);
    s_dst   = sub_vld_q[scnt_q] && dst_hit_q &&
              ((dst_q & sub_mask_q[scnt_q]) == sub_val_q[scnt_q]);
    s_hit   = s_src || s_dst;
    s_queue = s_src ? src_hq_q : dst_hq_q;
    s_addr  = s_src ? src_q : dst_q;
    s_qin   = 32'(s_queue) < QUEUE_COUNT;
  end

  assign q_ent = q_vld_q[qidx_q] ? q_rdata : '0;

  // remainder step and saturating charge
  logic [16:0] rem_t;
  logic [48:0] sum;
  logic [47:0] new_cnt;
  always_comb begin
    rem_t   = {rem_q, div_q[31]};
    sum     = {1'b0, qent_q.count} + 49'(len_q);
    new_cnt = sum[48] ? shqs_pkg::CntMax : sum[47:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      shqs_pkg::ST_CLEAR: begin
        if (hcnt_q == HIW'(HOST_ENTRIES - 1)) state_d = shqs_pkg::ST_IDLE;
      end
      shqs_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = shqs_pkg::ST_EXEC;
      end
      shqs_pkg::ST_EXEC: begin
        case (op_q)
          shqs_pkg::OP_CLASSIFY: state_d = shqs_pkg::ST_HSCAN;
          shqs_pkg::OP_WR_QUEUE, shqs_pkg::OP_RD_COUNT:
            state_d = slot_in_q ? shqs_pkg::ST_QDATA : shqs_pkg::ST_OUT;
          default: state_d = shqs_pkg::ST_OUT;
        endcase
      end
      shqs_pkg::ST_HSCAN: begin
        if (hcnt_q == HIW'(HOST_ENTRIES - 1)) state_d = shqs_pkg::ST_SSCAN;
      end
      shqs_pkg::ST_SSCAN: begin
        if (s_hit) state_d = s_qin ? shqs_pkg::ST_QDATA : shqs_pkg::ST_OUT;
        else if (scnt_q == SIW'(SUBNET_SLOTS - 1)) state_d = shqs_pkg::ST_OUT;
      end
      shqs_pkg::ST_QDATA: begin
        if (op_q == shqs_pkg::OP_CLASSIFY && q_ent.modulo > 16'd1) state_d = shqs_pkg::ST_MOD;
        else state_d = shqs_pkg::ST_OUT;
      end
      shqs_pkg::ST_MOD: begin
        if (bcnt_q == 5'd31) state_d = shqs_pkg::ST_QUPD;
      end
      shqs_pkg::ST_QUPD: state_d = shqs_pkg::ST_OUT;
      shqs_pkg::ST_OUT: begin
        if (!mvalid_q || m_axis_tready) state_d = shqs_pkg::ST_IDLE;
      end
      default: state_d = shqs_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    s_axis_tready = (state_q == shqs_pkg::ST_IDLE);
    h_we    = 1'b0;
    h_waddr = HIW'(slot_q);
    h_wdata = '{valid: evalid_q, queue: equeue_q, addr: eaddr_q};
    h_raddr = hcnt_q + HIW'(1);
    q_we    = 1'b0;
    q_waddr = qidx_q;
    q_wdata = '{modulo: emod_q, salt: esalt_q, count: q_ent.count};
    q_raddr = QIW'(slot_q);
    case (state_q)
      shqs_pkg::ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = hcnt_q;
        h_wdata = '0;
      end
      shqs_pkg::ST_EXEC: begin
        h_raddr = '0;
        h_we    = (op_q == shqs_pkg::OP_WR_HOST) && slot_in_host;
      end
      shqs_pkg::ST_SSCAN: q_raddr = QIW'(s_queue);
      shqs_pkg::ST_QDATA: q_we = (op_q == shqs_pkg::OP_WR_QUEUE);
      shqs_pkg::ST_QUPD: begin
        q_wdata = '{modulo: qent_q.modulo, salt: qent_q.salt, count: new_cnt};
        q_we    = (rem_q != 16'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= shqs_pkg::ST_CLEAR;
      hcnt_q    <= '0;
      sub_vld_q <= '0;
      q_vld_q   <= '0;
      mvalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == shqs_pkg::ST_OUT && (!mvalid_q || m_axis_tready)) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
      case (state_q)
        shqs_pkg::ST_CLEAR: hcnt_q <= hcnt_q + HIW'(1);
        shqs_pkg::ST_EXEC: begin
          hcnt_q <= '0;
          if (op_q == shqs_pkg::OP_WR_SUBNET && slot_in_sub) begin
            sub_vld_q[SIW'(slot_q)] <= evalid_q;
          end
        end
        shqs_pkg::ST_HSCAN: hcnt_q <= hcnt_q + HIW'(1);
        shqs_pkg::ST_QDATA: begin
          if (op_q == shqs_pkg::OP_WR_QUEUE) q_vld_q[qidx_q] <= 1'b1;
        end
        shqs_pkg::ST_QUPD: begin
          if (rem_q != 16'd0) q_vld_q[qidx_q] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      shqs_pkg::ST_IDLE: begin
        op_q     <= s_axis_tuser;
        src_q    <= s_axis_tdata[31:0];
        dst_q    <= s_axis_tdata[63:32];
        len_q    <= s_axis_tdata[79:64];
        slot_q   <= s_axis_tdata[85:80];
        eaddr_q  <= s_axis_tdata[117:86];
        emask_q  <= s_axis_tdata[149:118];
        equeue_q <= s_axis_tdata[153:150];
        evalid_q <= s_axis_tdata[154];
        emod_q   <= s_axis_tdata[170:155];
        esalt_q  <= s_axis_tdata[202:171];
      end
      shqs_pkg::ST_EXEC: begin
        pend_sel_q   <= 1'b0;
        pend_drop_q  <= 1'b0;
        pend_bytes_q <= '0;
        pend_queue_q <= (op_q == shqs_pkg::OP_RD_COUNT) ? slot_q[3:0] : 4'd0;
        qidx_q       <= QIW'(slot_q);
        src_hit_q    <= 1'b0;
        dst_hit_q    <= 1'b0;
        scnt_q       <= '0;
        if (op_q == shqs_pkg::OP_WR_SUBNET && slot_in_sub) begin
          sub_val_q[SIW'(slot_q)]  <= eaddr_q;
          sub_mask_q[SIW'(slot_q)] <= emask_q;
        end
      end
      shqs_pkg::ST_HSCAN: begin
        if (!src_hit_q && h_rdata.valid && h_rdata.addr == src_q) begin
          src_hit_q <= 1'b1;
          src_hq_q  <= h_rdata.queue;
        end
        if (!dst_hit_q && h_rdata.valid && h_rdata.addr == dst_q) begin
          dst_hit_q <= 1'b1;
          dst_hq_q  <= h_rdata.queue;
        end
      end
      shqs_pkg::ST_SSCAN: begin
        scnt_q <= scnt_q + SIW'(1);
        if (s_hit) begin
          pend_queue_q <= s_queue;
          pend_sel_q   <= !s_qin;
          sel_addr_q   <= s_addr;
          qidx_q       <= QIW'(s_queue);
        end
      end
      shqs_pkg::ST_QDATA: begin
        qent_q <= q_ent;
        rem_q  <= '0;
        bcnt_q <= '0;
        div_q  <= sel_addr_q ^ q_ent.salt;
        if (op_q == shqs_pkg::OP_RD_COUNT) pend_bytes_q <= q_ent.count;
        if (op_q == shqs_pkg::OP_CLASSIFY && q_ent.modulo <= 16'd1) pend_sel_q <= 1'b1;
      end
      shqs_pkg::ST_MOD: begin
        bcnt_q <= bcnt_q + 5'd1;
        div_q  <= {div_q[30:0], 1'b0};
        rem_q  <= (rem_t >= {1'b0, qent_q.modulo}) ? 16'(rem_t - {1'b0, qent_q.modulo})
                                                   : rem_t[15:0];
      end
      shqs_pkg::ST_QUPD: begin
        if (rem_q != 16'd0) begin
          pend_drop_q  <= 1'b1;
          pend_bytes_q <= new_cnt;
        end else begin
          pend_sel_q <= 1'b1;
        end
      end
      shqs_pkg::ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          out_sel_q   <= pend_sel_q;
          out_drop_q  <= pend_drop_q;
          out_queue_q <= pend_queue_q;
          out_bytes_q <= pend_bytes_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {4'd0, out_bytes_q, out_queue_q};
  assign m_axis_tuser  = {out_drop_q, out_sel_q};

endmodule

// ----- rtl/shqs_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module shqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
